[design/rrs_pkg.sv]
// Shared types and constants of the rectangle radiometric statistics block.
// Used by the front end, the queue, the back end and the top level.
// Depends on nothing.
package rrs_pkg;

  localparam int DIM_W      = 13;   // holds any row or column bound up to 4096
  localparam int ADDR_W     = 24;   // table address for the largest table
  localparam int COEF_W     = 32;
  localparam int PIX_W      = 16;
  localparam int RAD_W      = 48;
  localparam int SUM_W      = 64;
  localparam int CNT_W      = 19;
  localparam int ROW_W      = 9;
  localparam int COL_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ROWS_DEF   = 480;
  localparam int COLS_DEF   = 640;
  localparam int QUEUE_DEF  = 4;

  localparam logic [ROW_W-1:0] TOP_RESET    = ROW_W'(0);
  localparam logic [COL_W-1:0] LEFT_RESET   = COL_W'(0);
  localparam logic [ROW_W-1:0] BOTTOM_RESET = ROW_W'(479);
  localparam logic [COL_W-1:0] RIGHT_RESET  = COL_W'(639);
  localparam logic [CFG_DATA_W-1:0] SCALE_RESET = CFG_DATA_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOP_ROW    = 3'd0,
    REG_LEFT_COL   = 3'd1,
    REG_BOTTOM_ROW = 3'd2,
    REG_RIGHT_COL  = 3'd3,
    REG_SCALE      = 3'd4
  } cfg_reg_t;

  // One classified word passed from the front end to the back end.
  typedef struct packed {
    logic                     load;
    logic                     last;
    logic                     gain_ok;
    logic [ADDR_W-1:0]        addr;
    logic signed [COEF_W-1:0] gain;
    logic signed [COEF_W-1:0] offset;
    logic [PIX_W-1:0]         pix;
  } item_t;

  typedef struct packed {
    logic signed [RAD_W-1:0] max_rad;
    logic signed [RAD_W-1:0] mean_rad;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
    logic                    none;
  } result_t;

endpackage

[design/rrs_queue.sv]
// Short first-in first-out queue of classified words between front and back end.
// Depends on rrs_pkg for the word type.
module rrs_queue #(
  parameter int DEPTH = rrs_pkg::QUEUE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  rrs_pkg::item_t wr_item,
  output logic          full,
  input  logic          rd,
  output rrs_pkg::item_t rd_item,
  output logic          empty
);
  import rrs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  item_t          slots [DEPTH];
  logic [PW-1:0]  wp;
  logic [PW-1:0]  rp;
  logic [NW-1:0]  fill;

  assign full    = (fill == NW'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_item = slots[rp];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wp] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (wr && !full) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (rd && !empty) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      fill <= fill + NW'(wr && !full) - NW'(rd && !empty);
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= NW'(DEPTH))
    else $error("queue fill exceeds its depth");
`endif

endmodule

[design/rrs_front.sv]
// Front end: accepts input words, walks the rectangle and forms table addresses.
// Depends on rrs_pkg; feeds rrs_queue.
module rrs_front #(
  parameter int ROWS = rrs_pkg::ROWS_DEF,
  parameter int COLS = rrs_pkg::COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          mode,
  input  logic [rrs_pkg::ROW_W-1:0]     entry_row,
  input  logic [rrs_pkg::COL_W-1:0]     entry_col,
  input  logic signed [rrs_pkg::COEF_W-1:0] gain,
  input  logic signed [rrs_pkg::COEF_W-1:0] offset,
  input  logic                          gain_valid,
  input  logic [rrs_pkg::PIX_W-1:0]     pixel_count,
  input  logic [rrs_pkg::ROW_W-1:0]     roi_top_row,
  input  logic [rrs_pkg::COL_W-1:0]     roi_left_col,
  input  logic [rrs_pkg::ROW_W-1:0]     roi_bottom_row,
  input  logic [rrs_pkg::COL_W-1:0]     roi_right_col,
  output logic                          q_wr,
  output rrs_pkg::item_t                q_item,
  input  logic                          q_full
);
  import rrs_pkg::*;

  localparam logic [DIM_W-1:0]  ROW_LAST = DIM_W'(ROWS - 1);
  localparam logic [DIM_W-1:0]  COL_LAST = DIM_W'(COLS - 1);
  localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLS);

  logic [DIM_W-1:0] walk_row;
  logic [DIM_W-1:0] walk_col;
  logic [DIM_W-1:0] top, bot, left, right, bot_c, right_c;
  logic [DIM_W-1:0] row, col, row_sum, col_sum, ld_row, ld_col;
  logic             last_row, last_col, load_ok, accept;

  always_comb begin
    top     = ({4'b0, roi_top_row} > ROW_LAST) ? ROW_LAST : {4'b0, roi_top_row};
    bot_c   = ({4'b0, roi_bottom_row} > ROW_LAST) ? ROW_LAST : {4'b0, roi_bottom_row};
    bot     = (bot_c < top) ? top : bot_c;
    left    = ({3'b0, roi_left_col} > COL_LAST) ? COL_LAST : {3'b0, roi_left_col};
    right_c = ({3'b0, roi_right_col} > COL_LAST) ? COL_LAST : {3'b0, roi_right_col};
    right   = (right_c < left) ? left : right_c;
    row_sum = top + walk_row;
    col_sum = left + walk_col;
    row     = (row_sum > ROW_LAST) ? ROW_LAST : row_sum;
    col     = (col_sum > COL_LAST) ? COL_LAST : col_sum;
    last_row = (walk_row >= bot - top);
    last_col = (walk_col >= right - left);
    ld_row  = {4'b0, entry_row};
    ld_col  = {3'b0, entry_col};
    load_ok = (ld_row <= ROW_LAST) && (ld_col <= COL_LAST);
  end

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_wr   = accept && (mode || load_ok);

  always_comb begin
    q_item.load    = !mode;
    q_item.last    = last_row && last_col;
    q_item.gain_ok = gain_valid;
    q_item.gain    = gain;
    q_item.offset  = offset;
    q_item.pix     = pixel_count;
    if (mode) begin
      q_item.addr = ADDR_W'(row) * COLS_A + ADDR_W'(col);
    end else begin
      q_item.addr = ADDR_W'(ld_row) * COLS_A + ADDR_W'(ld_col);
    end
  end

  // Rows advance fastest, then columns.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_row <= '0;
      walk_col <= '0;
    end else if (accept && mode) begin
      if (!last_row) begin
        walk_row <= walk_row + DIM_W'(1);
      end else begin
        walk_row <= '0;
        walk_col <= last_col ? '0 : walk_col + DIM_W'(1);
      end
    end
  end

endmodule

[design/rrs_back.sv]
// Back end: coefficient table, calibration arithmetic, accumulation and the mean divider.
// Depends on rrs_pkg; drains rrs_queue and holds the result register.
module rrs_back #(
  parameter int ROWS = rrs_pkg::ROWS_DEF,
  parameter int COLS = rrs_pkg::COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [rrs_pkg::CFG_DATA_W-1:0] rad_scale,
  input  rrs_pkg::item_t                 q_item,
  input  logic                           q_empty,
  output logic                           q_rd,
  output rrs_pkg::result_t               res,
  output logic                           res_valid,
  input  logic                           res_pop
);
  import rrs_pkg::*;

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = 1 + 2 * COEF_W;
  localparam int VW    = RAD_W + 1;
  localparam logic [SUM_W-1:0] POS48 = SUM_W'(64'h0000_7FFF_FFFF_FFFF);
  localparam logic [SUM_W-1:0] NEG48 = SUM_W'(64'h0000_8000_0000_0000);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_ADD   = 8'b0000_0100,
    S_SCALE = 8'b0000_1000,
    S_ACC   = 8'b0001_0000,
    S_PREP  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [TW-1:0]            table_mem [DEPTH];
  logic [TW-1:0]            rd_word;
  logic                     last;
  logic [PIX_W-1:0]         pix;
  logic signed [VW-1:0]     prod;
  logic                     neg;
  logic [RAD_W-1:0]         mag;
  logic [SUM_W-1:0]         hi, lo;
  logic signed [RAD_W-1:0]  running_max;
  logic signed [SUM_W-1:0]  running_sum;
  logic [CNT_W-1:0]         running_count;
  logic [SUM_W-1:0]         quo;
  logic [CNT_W:0]           rem;
  logic [5:0]               step;

  logic signed [VW-1:0]     v;
  logic [SUM_W-1:0]         q_pos, q_neg;
  logic signed [RAD_W-1:0]  rad;
  logic signed [SUM_W-1:0]  rad_x, sum_raw, sum_sat;
  logic [CNT_W+1:0]         trial;
  logic [SUM_W-1:0]         sum_mag, mean_x;
  logic signed [RAD_W-1:0]  mean_c;
  logic                     slot_free;

  assign q_rd      = (state == S_IDLE) && !q_empty;
  assign slot_free = !res_valid || res_pop;

  // The table has a single port: a load writes, a measurement reads.
  always_ff @(posedge clk) begin
    if (q_rd) begin
      if (q_item.load) begin
        table_mem[q_item.addr[AW-1:0]] <= {q_item.gain_ok, q_item.gain, q_item.offset};
      end else begin
        rd_word <= table_mem[q_item.addr[AW-1:0]];
      end
    end
  end

  always_comb begin
    v     = prod + VW'($signed(rd_word[COEF_W-1:0]));
    q_pos = hi + (lo >> 16);
    q_neg = hi + ((lo + SUM_W'(16'hFFFF)) >> 16);
    if (!neg) begin
      rad = (q_pos > POS48) ? RAD_W'(POS48) : RAD_W'(q_pos);
    end else begin
      rad = (q_neg > NEG48) ? RAD_W'(NEG48) : RAD_W'(-q_neg);
    end
    rad_x   = SUM_W'(rad);
    sum_raw = running_sum + rad_x;
    if (running_sum[SUM_W-1] == rad_x[SUM_W-1] && sum_raw[SUM_W-1] != rad_x[SUM_W-1]) begin
      sum_sat = rad_x[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_raw;
    end
    trial = {rem, quo[SUM_W-1]};
    sum_mag = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);
    if (!running_sum[SUM_W-1]) begin
      mean_x = quo;
      mean_c = (quo > POS48) ? RAD_W'(POS48) : RAD_W'(quo);
    end else begin
      mean_x = SUM_W'(-quo);
      mean_c = (quo > NEG48) ? RAD_W'(NEG48) : RAD_W'(mean_x);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (q_rd && !q_item.load) state_next = S_MUL;
      S_MUL:   state_next = rd_word[TW-1] ? S_ADD : (last ? S_PREP : S_IDLE);
      S_ADD:   state_next = S_SCALE;
      S_SCALE: state_next = S_ACC;
      S_ACC:   state_next = last ? S_PREP : S_IDLE;
      S_PREP:  state_next = (running_count == '0) ? S_EMIT : S_DIV;
      S_DIV:   if (step == 6'd63) state_next = S_EMIT;
      S_EMIT:  if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      last <= q_item.last;
      pix  <= q_item.pix;
    end
    if (state == S_MUL) begin
      prod <= VW'($signed(rd_word[TW-2:COEF_W])) * VW'($signed({1'b0, pix}));
    end
    if (state == S_ADD) begin
      neg <= v[VW-1];
      mag <= v[VW-1] ? RAD_W'(-v) : RAD_W'(v);
    end
    if (state == S_SCALE) begin
      hi <= SUM_W'(mag) * SUM_W'(rad_scale[31:16]);
      lo <= SUM_W'(mag) * SUM_W'(rad_scale[15:0]);
    end
    // Restoring division of the sum's magnitude by the count, one bit a cycle.
    if (state == S_PREP) begin
      quo  <= sum_mag;
      rem  <= '0;
    end
    if (state == S_DIV) begin
      if (trial >= {2'b0, running_count}) begin
        rem <= (CNT_W+1)'(trial - {2'b0, running_count});
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[CNT_W:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
    if (state == S_EMIT && slot_free) begin
      if (running_count == '0) begin
        res <= '{max_rad: '0, mean_rad: '0, sum: '0, count: '0, none: 1'b1};
      end else begin
        res <= '{max_rad: running_max, mean_rad: mean_c, sum: running_sum,
                 count: running_count, none: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= '0;
      res_valid     <= 1'b0;
      running_max   <= '0;
      running_sum   <= '0;
      running_count <= '0;
    end else begin
      state <= state_next;
      step  <= (state == S_DIV) ? step + 6'd1 : '0;
      if (state == S_ACC) begin
        if (running_count == '0 || rad > running_max) begin
          running_max <= rad;
        end
        running_sum <= sum_sat;
        if (running_count != {CNT_W{1'b1}}) begin
          running_count <= running_count + CNT_W'(1);
        end
      end
      if (state == S_EMIT && slot_free) begin
        res_valid     <= 1'b1;
        running_max   <= '0;
        running_sum   <= '0;
        running_count <= '0;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> state == S_IDLE && !q_empty)
    else $error("queue read outside the idle state");
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.none |-> res.count == '0 && res.sum == '0)
    else $error("empty rectangle result carries data");
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && slot_free |=> running_count == '0 && res_valid)
    else $error("accumulators not cleared on result");
`endif

endmodule

[design/roi_radiometric_statistics.sv]
// Top level of the rectangle radiometric statistics block: registers, front, queue, back.
// Depends on rrs_pkg, rrs_front, rrs_queue and rrs_back.
//
//  channel   handshake          payload
//  input     push / full        mode, entry_row, entry_col, gain, offset, gain_valid,
//                               pixel_count
//  result    pop / empty        max_radiance, mean_radiance, sum_radiance, valid_count,
//                               no_valid_pixels
//  config    cfg_valid/ready    cfg_index, cfg_data
//
// A load word is written to the table from the idle state; a pixel passes table read, multiply,
// offset add, scale multiply and accumulate, set by the single-port table and the multipliers.
// A pixel whose gain is marked invalid stops after the table read and the validity check.
// The last pixel of a rectangle adds a set-up step, bit-serial mean divider steps over the
// 64 quotient bits and a result write; with no valid pixel it adds only set-up and write.
// The front end takes a word whenever the four-entry queue has room; a result left waiting
// holds the back end at the result write, so the queue fills and full rises.
// Reset is synchronous and clears control state; the table is undefined until loaded.
module roi_radiometric_statistics #(
  parameter int ROWS  = rrs_pkg::ROWS_DEF,
  parameter int COLS  = rrs_pkg::COLS_DEF,
  parameter int QUEUE = rrs_pkg::QUEUE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic                               mode,
  input  logic [rrs_pkg::ROW_W-1:0]          entry_row,
  input  logic [rrs_pkg::COL_W-1:0]          entry_col,
  input  logic signed [rrs_pkg::COEF_W-1:0]  gain,
  input  logic signed [rrs_pkg::COEF_W-1:0]  offset,
  input  logic                               gain_valid,
  input  logic [rrs_pkg::PIX_W-1:0]          pixel_count,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [rrs_pkg::RAD_W-1:0]   max_radiance,
  output logic signed [rrs_pkg::RAD_W-1:0]   mean_radiance,
  output logic signed [rrs_pkg::SUM_W-1:0]   sum_radiance,
  output logic [rrs_pkg::CNT_W-1:0]          valid_count,
  output logic                               no_valid_pixels,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rrs_pkg::*;

  logic [ROW_W-1:0]      roi_top_row, roi_bottom_row;
  logic [COL_W-1:0]      roi_left_col, roi_right_col;
  logic [CFG_DATA_W-1:0] rad_scale;
  logic                  q_wr, q_full, q_rd, q_empty, res_valid;
  item_t                 q_in, q_out;
  result_t               res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      roi_top_row    <= TOP_RESET;
      roi_left_col   <= LEFT_RESET;
      roi_bottom_row <= BOTTOM_RESET;
      roi_right_col  <= RIGHT_RESET;
      rad_scale      <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TOP_ROW:    roi_top_row    <= cfg_data[ROW_W-1:0];
        REG_LEFT_COL:   roi_left_col   <= cfg_data[COL_W-1:0];
        REG_BOTTOM_ROW: roi_bottom_row <= cfg_data[ROW_W-1:0];
        REG_RIGHT_COL:  roi_right_col  <= cfg_data[COL_W-1:0];
        REG_SCALE:      rad_scale      <= cfg_data;
        default: ;
      endcase
    end
  end

  rrs_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
    .clk, .rst, .push, .full, .mode, .entry_row, .entry_col, .gain, .offset,
    .gain_valid, .pixel_count, .roi_top_row, .roi_left_col, .roi_bottom_row,
    .roi_right_col, .q_wr, .q_item(q_in), .q_full
  );

  rrs_queue #(.DEPTH(QUEUE)) u_queue (
    .clk, .rst, .wr(q_wr), .wr_item(q_in), .full(q_full),
    .rd(q_rd), .rd_item(q_out), .empty(q_empty)
  );

  rrs_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
    .clk, .rst, .rad_scale, .q_item(q_out), .q_empty, .q_rd,
    .res, .res_valid, .res_pop(pop)
  );

  assign empty           = !res_valid;
  assign max_radiance    = res.max_rad;
  assign mean_radiance   = res.mean_rad;
  assign sum_radiance    = res.sum;
  assign valid_count     = res.count;
  assign no_valid_pixels = res.none;

endmodule

[tb/sv/rrs_checker.sv]
`timescale 1ns / 1ps
// Checker for roi_radiometric_statistics: watches the input, result and register channels.
// Predicts each result from its own copy of the table and statistics and compares them.
// Depends on rrs_pkg.
module rrs_checker
  import rrs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic                     full,
  input  logic                     mode,
  input  logic [ROW_W-1:0]         entry_row,
  input  logic [COL_W-1:0]         entry_col,
  input  logic signed [COEF_W-1:0] gain,
  input  logic signed [COEF_W-1:0] offset,
  input  logic                     gain_valid,
  input  logic [PIX_W-1:0]         pixel_count,
  input  logic                     empty,
  input  logic                     pop,
  input  logic signed [RAD_W-1:0]  max_radiance,
  input  logic signed [RAD_W-1:0]  mean_radiance,
  input  logic signed [SUM_W-1:0]  sum_radiance,
  input  logic [CNT_W-1:0]         valid_count,
  input  logic                     no_valid_pixels,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output int                       errors,
  output int                       pending
);

  localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint MIN48 = -64'sh0000_8000_0000_0000;
  localparam longint MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint MIN64 = 64'sh8000_0000_0000_0000;
  localparam int     ROWS  = ROWS_DEF;
  localparam int     COLS  = COLS_DEF;

  // Coefficient table, only entries that were loaded exist.
  bit [31:0] gain_tab[int];
  bit [31:0] offset_tab[int];
  bit        usable_tab[int];

  int unsigned top_r, left_r, bot_r, right_r;
  bit [31:0]   scale_r;
  int unsigned walk_r, walk_c;
  longint      run_max, run_sum;
  int unsigned run_cnt;
  result_t     stats_due[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic longint scale_radiance(longint v, bit [31:0] s);
    bit [63:0] mag, hi, lo, q;
    mag = v < 0 ? 64'(-v) : 64'(v);
    hi  = mag * 64'(s[31:16]);
    lo  = mag * 64'(s[15:0]);
    if (v >= 0) begin
      q = hi + (lo >> 16);
      return q > 64'(MAX48) ? MAX48 : longint'(q);
    end
    q = hi + ((lo + 64'hFFFF) >> 16);
    return q > 64'h8000_0000_0000 ? MIN48 : -longint'(q);
  endfunction

  function automatic longint add_saturating(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? MIN64 : MAX64;
    return s;
  endfunction

  function automatic int unsigned clip(int unsigned v, int unsigned hi);
    return v > hi ? hi : v;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  task automatic predict_pixel(bit [15:0] cnt);
    int unsigned t, b, l, r, row, col, idx;
    longint      v, rad, mean;
    result_t     res;
    t = clip(top_r, ROWS - 1);
    b = clip(bot_r, ROWS - 1);
    if (b < t) b = t;
    l = clip(left_r, COLS - 1);
    r = clip(right_r, COLS - 1);
    if (r < l) r = l;
    row = clip(t + walk_r, ROWS - 1);
    col = clip(l + walk_c, COLS - 1);
    idx = row * COLS + col;
    if (usable_tab.exists(idx) && usable_tab[idx]) begin
      v = longint'(signed'(gain_tab[idx])) * longint'({16'd0, cnt})
          + longint'(signed'(offset_tab[idx]));
      rad = scale_radiance(v, scale_r);
      if (run_cnt == 0 || rad > run_max) run_max = rad;
      run_sum = add_saturating(run_sum, rad);
      if (run_cnt < 32'h7FFFF) run_cnt++;
    end
    if (walk_r < b - t) begin
      walk_r++;
      return;
    end
    walk_r = 0;
    if (walk_c < r - l) begin
      walk_c++;
      return;
    end
    walk_c = 0;
    res = '0;
    if (run_cnt == 0) begin
      res.none = 1'b1;
    end else begin
      mean = run_sum / longint'(run_cnt);
      if (mean > MAX48) mean = MAX48;
      if (mean < MIN48) mean = MIN48;
      res.max_rad  = run_max[RAD_W-1:0];
      res.mean_rad = mean[RAD_W-1:0];
      res.sum      = run_sum;
      res.count    = run_cnt[CNT_W-1:0];
    end
    stats_due = {stats_due, res};
    run_max = 0;
    run_sum = 0;
    run_cnt = 0;
  endtask

  always @(posedge clk) begin
    result_t want;
    int      idx;
    if (rst) begin
      top_r = TOP_RESET;
      left_r = LEFT_RESET;
      bot_r = BOTTOM_RESET;
      right_r = RIGHT_RESET;
      scale_r = SCALE_RESET;
      walk_r = 0;
      walk_c = 0;
      run_max = 0;
      run_sum = 0;
      run_cnt = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_TOP_ROW:    top_r = cfg_data[ROW_W-1:0];
          REG_LEFT_COL:   left_r = cfg_data[COL_W-1:0];
          REG_BOTTOM_ROW: bot_r = cfg_data[ROW_W-1:0];
          REG_RIGHT_COL:  right_r = cfg_data[COL_W-1:0];
          REG_SCALE:      scale_r = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        if (!mode) begin
          if (entry_row < ROWS && entry_col < COLS) begin
            idx = int'(entry_row) * COLS + int'(entry_col);
            gain_tab[idx]   = gain;
            offset_tab[idx] = offset;
            usable_tab[idx] = gain_valid;
          end
        end else begin
          predict_pixel(pixel_count);
        end
      end
      if (pop && !empty) begin
        if (stats_due.size() == 0) begin
          $display("result word arrived with none expected");
          errors++;
        end else begin
          want = stats_due.pop_front();
          if (max_radiance !== want.max_rad) report("max_radiance", max_radiance, want.max_rad);
          if (mean_radiance !== want.mean_rad)
            report("mean_radiance", mean_radiance, want.mean_rad);
          if (sum_radiance !== want.sum) report("sum_radiance", sum_radiance, want.sum);
          if (valid_count !== want.count) report("valid_count", valid_count, want.count);
          if (no_valid_pixels !== want.none)
            report("no_valid_pixels", no_valid_pixels, want.none);
        end
      end
    end
    pending = stats_due.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Top of the testbench for roi_radiometric_statistics: clock, reset, stimulus and verdict.
// Depends on rrs_pkg, roi_radiometric_statistics and rrs_checker.
module tb;
  import rrs_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     push = 1'b0, full;
  logic                     mode = 1'b0;
  logic [ROW_W-1:0]         entry_row = '0;
  logic [COL_W-1:0]         entry_col = '0;
  logic signed [COEF_W-1:0] gain = '0, offset = '0;
  logic                     gain_valid = 1'b0;
  logic [PIX_W-1:0]         pixel_count = '0;
  logic                     empty, pop = 1'b0;
  logic signed [RAD_W-1:0]  max_radiance, mean_radiance;
  logic signed [SUM_W-1:0]  sum_radiance;
  logic [CNT_W-1:0]         valid_count;
  logic                     no_valid_pixels;
  logic                     cfg_valid = 1'b0, cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  int                       errors, pending;

  int unsigned top_r = TOP_RESET, left_r = LEFT_RESET;
  int unsigned bot_r = BOTTOM_RESET, right_r = RIGHT_RESET;
  int          words_sent = 0;
  int          pops_done = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  roi_radiometric_statistics DUT (.*);

  rrs_checker checker_i (.*);

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random stalls, and one long hold-off while a burst is still being offered.
  initial begin
    int stall;
    forever begin
      stall = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (pops_done == 5) stall = 1000;
      @(negedge clk);
      pop = 1'b0;
      repeat (stall) @(negedge clk);
      pop = 1'b1;
      #1;
      while (empty) begin
        @(negedge clk);
        #1;
      end
      @(posedge clk);
      pops_done++;
    end
  end

  task automatic send_word(bit m, bit [8:0] r, bit [9:0] c, bit [31:0] g, bit [31:0] o,
                           bit gv, bit [15:0] px, bit nogap);
    int gap;
    gap = nogap ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 2) == 0) gap = 0;
    @(negedge clk);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode = m;
    entry_row = r;
    entry_col = c;
    gain = g;
    offset = o;
    gain_valid = gv;
    pixel_count = px;
    push = 1'b1;
    #1;
    while (full) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    words_sent++;
  endtask

  task automatic end_push();
    @(negedge clk);
    push = 1'b0;
  endtask

  // Registers are only written with the block drained, plus the divider's latency.
  task automatic write_reg(cfg_reg_t idx, bit [31:0] val);
    end_push();
    wait (pending == 0);
    repeat (90) @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    #1;
    while (!cfg_ready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    case (idx)
      REG_TOP_ROW:    top_r = val[ROW_W-1:0];
      REG_LEFT_COL:   left_r = val[COL_W-1:0];
      REG_BOTTOM_ROW: bot_r = val[ROW_W-1:0];
      REG_RIGHT_COL:  right_r = val[COL_W-1:0];
      default: ;
    endcase
  endtask

  function automatic bit [31:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4, 5: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      default: return $urandom;
    endcase
  endfunction

  function automatic bit [15:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Loads every entry of the clamped rectangle so that no unloaded entry is read.
  task automatic load_rect(int dead_pct);
    int unsigned t, b, l, r;
    t = top_r > 479 ? 479 : top_r;
    b = bot_r > 479 ? 479 : bot_r;
    if (b < t) b = t;
    l = left_r > 639 ? 639 : left_r;
    r = right_r > 639 ? 639 : right_r;
    if (r < l) r = l;
    for (int unsigned c = l; c <= r; c++)
      for (int unsigned rw = t; rw <= b; rw++)
        send_word(1'b0, rw, c, pick_gain(), $urandom,
                  $urandom_range(0, 99) >= dead_pct, $urandom, 1'b0);
  endtask

  task automatic measure(int pixels, bit burst);
    for (int i = 0; i < pixels; i++)
      send_word(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, pick_count(), burst);
  endtask

  function automatic int rect_area();
    int unsigned t, b, l, r;
    t = top_r > 479 ? 479 : top_r;
    b = bot_r > 479 ? 479 : bot_r;
    if (b < t) b = t;
    l = left_r > 639 ? 639 : left_r;
    r = right_r > 639 ? 639 : right_r;
    if (r < l) r = l;
    return (b - t + 1) * (r - l + 1);
  endfunction

  initial begin
    int h, w, passes;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: a 2x2 rectangle with extreme coefficients and counts.
    write_reg(REG_BOTTOM_ROW, 1);
    write_reg(REG_RIGHT_COL, 1);
    send_word(1'b0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 0, 1'b0);
    send_word(1'b0, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 0, 1'b0);
    send_word(1'b0, 0, 1, 32'h0001_0000, 32'h0, 1'b1, 0, 1'b0);
    send_word(1'b0, 1, 1, 32'h0002_0000, 32'hFFFF_0000, 1'b0, 0, 1'b0);
    // Loads outside the table are dropped.
    send_word(1'b0, 480, 0, 32'h0, 32'h0, 1'b0, 0, 1'b0);
    send_word(1'b0, 0, 640, 32'h0, 32'h0, 1'b0, 0, 1'b0);
    send_word(1'b0, 511, 1023, 32'h0, 32'h0, 1'b0, 0, 1'b0);
    send_word(1'b1, 0, 0, 0, 0, 0, 16'hFFFF, 1'b0);
    send_word(1'b1, 0, 0, 0, 0, 0, 16'hFFFF, 1'b0);
    send_word(1'b1, 0, 0, 0, 0, 0, 16'h0, 1'b0);
    send_word(1'b1, 0, 0, 0, 0, 0, 16'h1234, 1'b0);
    write_reg(REG_SCALE, 32'hFFFF_FFFF);
    measure(4, 1'b1);
    write_reg(REG_SCALE, 32'h0);
    measure(4, 1'b0);
    // No valid pixel at all.
    write_reg(REG_SCALE, 32'h0001_0000);
    write_reg(REG_TOP_ROW, 1);
    write_reg(REG_LEFT_COL, 1);
    measure(1, 1'b0);
    // Bounds shrunk part way through a rectangle end the walk early.
    write_reg(REG_TOP_ROW, 0);
    write_reg(REG_LEFT_COL, 0);
    measure(3, 1'b0);
    write_reg(REG_BOTTOM_ROW, 0);
    measure(1, 1'b0);
    // A burst into the two-pixel rectangle while the result side holds off fills the queue.
    measure(16, 1'b1);

    // Random phases: small rectangles, fully loaded, then measured a few times.
    while (words_sent < 1700) begin
      h = $urandom_range(0, 2) == 0 ? 1 : $urandom_range(1, 4);
      w = $urandom_range(0, 2) == 0 ? 1 : $urandom_range(1, 4);
      if ($urandom_range(0, 15) == 0) begin
        h = $urandom_range(5, 8);
        w = $urandom_range(5, 8);
      end
      case ($urandom_range(0, 7))
        0: begin
          // Bounds out of range or crossed, left to the clamping.
          write_reg(REG_TOP_ROW, $urandom_range(470, 511));
          write_reg(REG_BOTTOM_ROW, $urandom_range(0, 511));
          write_reg(REG_LEFT_COL, $urandom_range(630, 1023));
          write_reg(REG_RIGHT_COL, $urandom_range(0, 1023));
        end
        1: begin
          write_reg(REG_TOP_ROW, 480 - h);
          write_reg(REG_BOTTOM_ROW, 479);
          write_reg(REG_LEFT_COL, 640 - w);
          write_reg(REG_RIGHT_COL, 639);
        end
        default: begin
          top_r = $urandom_range(0, 480 - h);
          left_r = $urandom_range(0, 640 - w);
          write_reg(REG_TOP_ROW, top_r);
          write_reg(REG_BOTTOM_ROW, top_r + h - 1);
          write_reg(REG_LEFT_COL, left_r);
          write_reg(REG_RIGHT_COL, left_r + w - 1);
        end
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(REG_SCALE, 32'h0);
        1: write_reg(REG_SCALE, 32'hFFFF_FFFF);
        2: write_reg(REG_SCALE, 32'h0001_0000);
        3: write_reg(REG_SCALE, $urandom);
        default: write_reg(REG_SCALE, $urandom_range(0, 32'h0004_0000));
      endcase
      load_rect($urandom_range(0, 3) == 0 ? 100 : 10);
      // Stray loads anywhere, some outside the table.
      repeat ($urandom_range(0, 2))
        send_word(1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
      passes = rect_area() == 1 ? $urandom_range(1, 10) : $urandom_range(1, 3);
      measure(passes * rect_area(), $urandom_range(0, 2) == 0);
    end
    end_push();

    for (int k = 0; k < 200000 && pending != 0; k++) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
